// ===== rtl/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// tks_pkg
// Types and constants shared by the tabu knapsack move step block.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int MaxItems  = 32;
  localparam int TabuDepth = 5;
  localparam int NumLanes  = 4;
  localparam int LaneItems = MaxItems / NumLanes;
  localparam int IdxW      = $clog2(MaxItems);
  localparam int LaneCntW  = $clog2(LaneItems);
  localparam int TabuIdxW  = $clog2(TabuDepth);
  localparam int TabuCntW  = $clog2(TabuDepth + 1);

  localparam logic [28:0] CapReset   = 29'd6404180;
  localparam logic [5:0]  ItemsReset = 6'd24;

  // request codes
  localparam logic [1:0] ReqLoad  = 2'd0;
  localparam logic [1:0] ReqStart = 2'd1;
  localparam logic [1:0] ReqMove  = 2'd2;
  localparam logic [1:0] ReqBad   = 2'd3;

  // configuration register indexes
  localparam logic [0:0] CfgCapacity = 1'd0;
  localparam logic [0:0] CfgNumItems = 1'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  item_index;
    logic [23:0] item_weight;
    logic [23:0] item_value;
    logic [31:0] start_solution;
    logic [4:0]  range_a;
    logic [4:0]  range_b;
    logic [31:0] random_bits;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] solution;
    logic [28:0] solution_value;
    logic [28:0] candidate_value;
    logic        was_tabu;
    logic        accepted;
  } out_beat_t;

  // lane control from the sequencer
  typedef struct packed {
    logic                clear;
    logic                step;
    logic [LaneCntW-1:0] pos;
  } lane_ctl_t;

endpackage

// ===== rtl/tks_lane.sv =====
// ----------------------------------------------------------------------------
// tks_lane
// One evaluation lane: holds its slice of the item table and accumulates the
// weight and value of selected items, one item per cycle.
// ----------------------------------------------------------------------------
module tks_lane (
  input  logic                          clk,
  input  tks_pkg::lane_ctl_t            ctl,
  input  logic                          ld_en,
  input  logic [tks_pkg::LaneCntW-1:0]  ld_addr,
  input  logic [23:0]                   ld_weight,
  input  logic [23:0]                   ld_value,
  input  logic [tks_pkg::LaneItems-1:0] sel,
  output logic [28:0]                   sum_w,
  output logic [28:0]                   sum_v
);
  import tks_pkg::*;

  logic [23:0] wmem [LaneItems];
  logic [23:0] vmem [LaneItems];
  logic [23:0] w_rd_r, v_rd_r;
  logic        take_r, acc_r;
  logic [28:0] sum_w_r, sum_v_r;

  // item storage, registered read
  always_ff @(posedge clk) begin
    if (ld_en) begin
      wmem[ld_addr] <= ld_weight;
      vmem[ld_addr] <= ld_value;
    end
    w_rd_r <= wmem[ctl.pos];
    v_rd_r <= vmem[ctl.pos];
    take_r <= sel[ctl.pos];
    acc_r  <= ctl.step;
  end

  // accumulate one item a cycle
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_w_r <= '0;
      sum_v_r <= '0;
    end else if (acc_r && take_r) begin
      sum_w_r <= sum_w_r + 29'(w_rd_r);
      sum_v_r <= sum_v_r + 29'(v_rd_r);
    end
  end

  assign sum_w = sum_w_r;
  assign sum_v = sum_v_r;
endmodule

// ===== rtl/tks_merge.sv =====
// ----------------------------------------------------------------------------
// tks_merge
// Combines the lane sums into a total and checks it against capacity.
// ----------------------------------------------------------------------------
module tks_merge (
  input  logic        clk,
  input  logic [28:0] lane_w [tks_pkg::NumLanes],
  input  logic [28:0] lane_v [tks_pkg::NumLanes],
  input  logic [28:0] capacity,
  output logic [28:0] value
);
  import tks_pkg::*;

  logic [30:0] tw_r;
  logic [28:0] tv_r;
  logic [30:0] tw;
  logic [28:0] tv;

  always_comb begin
    tw = '0;
    tv = '0;
    for (int l = 0; l < NumLanes; l++) begin
      tw = tw + 31'(lane_w[l]);
      tv = tv + lane_v[l];
    end
  end

  always_ff @(posedge clk) begin
    tw_r <= tw;
    tv_r <= tv;
  end

  assign value = (tw_r > 31'(capacity)) ? '0 : tv_r;
endmodule

// ===== rtl/tabu_knapsack_move_step.sv =====
// ----------------------------------------------------------------------------
// tabu_knapsack_move_step
// Each request takes one beat and produces one result beat. Load and unknown
// requests go straight to output; a move whose candidate is in the tabu list
// is answered after the candidate and tabu check states. Evaluation scans the
// item table in 4 lanes of 8 items, one item per lane per cycle, then drains
// the lane and merge registers and commits; a move first forms the candidate
// and checks the tabu list. One request is in flight at a time, and the next
// beat is accepted once the block is idle and its result is not held off.
// ----------------------------------------------------------------------------
module tabu_knapsack_move_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tks_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tks_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [28:0]        cfg_data
);
  import tks_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CAND, S_CHECK, S_CLEAR, S_SCAN, S_MERGE, S_OUT}
    state_t;

  state_t state_r;
  in_beat_t req_r;
  logic [28:0] cap_r;
  logic [5:0] nitems_r;
  logic [31:0] cur_bits_r, cand_r;
  logic [28:0] cur_val_r;
  logic [31:0] tabu_r [TabuDepth];
  logic [TabuCntW-1:0] tcnt_r;
  logic [LaneCntW:0] cnt_r;
  logic [1:0] wait_r;
  logic hit_r;
  out_beat_t out_r;
  logic out_valid_r;
  lane_ctl_t ctl;
  logic [28:0] lane_w [NumLanes];
  logic [28:0] lane_v [NumLanes];
  logic [28:0] eval_v;
  logic [31:0] umask, rmask, cand;
  logic [4:0] lo, hi;
  logic hit;

  // mask of items in use, move range mask, candidate and tabu list lookup
  always_comb begin
    umask = '0;
    for (int i = 0; i < 32; i++) umask[i] = (6'(i) < nitems_r);
    lo = (req_r.range_a < req_r.range_b) ? req_r.range_a : req_r.range_b;
    hi = (req_r.range_a < req_r.range_b) ? req_r.range_b : req_r.range_a;
    for (int i = 0; i < 32; i++) rmask[i] = (5'(i) >= lo) && (5'(i) <= hi);
    cand = ((cur_bits_r & ~rmask) | (req_r.random_bits & rmask)) & umask;
    hit = 1'b0;
    for (int i = 0; i < TabuDepth; i++)
      if (TabuCntW'(i) < tcnt_r && tabu_r[i] == cand_r) hit = 1'b1;
  end

  assign ctl.clear = (state_r == S_CLEAR);
  assign ctl.step  = (state_r == S_SCAN);
  assign ctl.pos   = cnt_r[LaneCntW-1:0];

  // lanes, each holding items l*LaneItems .. l*LaneItems+LaneItems-1
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    tks_lane u_lane (
      .clk(clk), .ctl(ctl),
      .ld_en(state_r == S_IDLE && in_valid && !in_stall &&
             in_data.req_type == ReqLoad &&
             in_data.item_index[IdxW-1:LaneCntW] == 2'(l)),
      .ld_addr(in_data.item_index[LaneCntW-1:0]),
      .ld_weight(in_data.item_weight), .ld_value(in_data.item_value),
      .sel(cand_r[l*LaneItems +: LaneItems]),
      .sum_w(lane_w[l]), .sum_v(lane_v[l])
    );
  end

  tks_merge u_merge (.clk(clk), .lane_w(lane_w), .lane_v(lane_v),
                     .capacity(cap_r), .value(eval_v));

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r <= CapReset;
      nitems_r <= ItemsReset;
      cur_bits_r <= '0;
      cur_val_r <= '0;
      tcnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgCapacity) cap_r <= cfg_data;
        else nitems_r <= (cfg_data[5:0] > 6'd32) ? 6'd32 : cfg_data[5:0];
      end
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_r <= in_data;
            out_r <= '0;
            case (in_data.req_type)
              ReqStart: begin
                cand_r <= in_data.start_solution;
                state_r <= S_CLEAR;
              end
              ReqMove: begin
                state_r <= S_CAND;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_CAND: begin  // form candidate
          cand_r <= cand;
          state_r <= S_CHECK;
        end
        S_CHECK: begin  // tabu list lookup
          hit_r <= hit;
          state_r <= hit ? S_OUT : S_CLEAR;
        end
        S_CLEAR: begin  // clear lanes, mask start selection
          if (req_r.req_type == ReqStart) begin
            cand_r <= cand_r & umask;
            cur_bits_r <= cand_r & umask;
          end
          cnt_r <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == (LaneCntW+1)'(LaneItems - 1)) begin
            wait_r <= 2'd0;
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (wait_r != 2'd2) begin
            wait_r <= wait_r + 1'b1;  // drain lane and merge registers
          end else begin
            // evaluation finished
            if (req_r.req_type == ReqStart) begin
              cur_val_r <= eval_v;
              tcnt_r <= '0;
            end else begin
              out_r.candidate_value <= eval_v;
              if (tcnt_r == TabuCntW'(TabuDepth)) begin
                for (int i = 0; i < TabuDepth - 1; i++) tabu_r[i] <= tabu_r[i+1];
                tabu_r[TabuDepth-1] <= cand_r;
              end else begin
                tabu_r[tcnt_r[TabuIdxW-1:0]] <= cand_r;
                tcnt_r <= tcnt_r + 1'b1;
              end
              if (eval_v > cur_val_r) begin
                cur_bits_r <= cand_r;
                cur_val_r <= eval_v;
                out_r.accepted <= 1'b1;
              end
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_r.solution <= cur_bits_r;
            out_r.solution_value <= cur_val_r;
            out_r.was_tabu <= hit_r && req_r.req_type == ReqMove;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= TabuCntW'(TabuDepth)) else $error("tabu count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("accept while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |-> !out_data.was_tabu)
    else $error("tabu candidate accepted");
endmodule
